// File: rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 stream transcoder.
`default_nettype none
package u8u16_pkg;

  localparam int unsigned CodeW = 21;
  localparam int unsigned UnitW = 16;

  localparam logic [3:0] NibLead2a = 4'hC;
  localparam logic [3:0] NibLead2b = 4'hD;
  localparam logic [3:0] NibLead3  = 4'hE;
  localparam logic [3:0] NibLead4  = 4'hF;

  localparam logic [CodeW-1:0] BmpMax    = 21'h00FFFF;
  localparam logic [CodeW-1:0] SuppBase  = 21'h010000;
  localparam logic [UnitW-1:0] HighSurr  = 16'hD800;
  localparam logic [5:0]       LowSurrHi = 6'b110111;

  // Units produced by one byte, in output order.
  typedef struct packed {
    logic [1:0]       count;
    logic [UnitW-1:0] unit0;
    logic [UnitW-1:0] unit1;
  } dec_out_t;

endpackage
`default_nettype wire

// File: rtl/utf8_to_utf16_stream_top.sv
// UTF-8 to UTF-16 stream transcoder, top level with the input register.
// A byte waits in the input register; its code units then go to the output buffer.
// Throughput: one byte per cycle while out_stall is low; after a byte that gives a
// surrogate pair, the next unit-giving byte waits until the high surrogate is taken.
// Reset (synchronous, active high) closes any open sequence and empties both stages.
`default_nettype none
module utf8_to_utf16_stream_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             byte_in,
  input  wire logic                   final_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [u8u16_pkg::UnitW-1:0] code_unit,
  output logic                        run_end
);
  import u8u16_pkg::*;

  logic       hold_valid;
  logic [7:0] byte_q;
  logic       final_q;
  logic       load_ok;
  logic       advance;
  dec_out_t   dec;

  assign advance  = hold_valid && load_ok;
  assign in_stall = hold_valid && !load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_q  <= byte_in;
      final_q <= final_byte;
    end
  end

  u8u16_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_q  (byte_q),
    .final_q (final_q),
    .dec     (dec)
  );

  u8u16_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .dec       (dec),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_unit (code_unit),
    .run_end   (run_end)
  );

endmodule
`default_nettype wire

// File: rtl/u8u16_decode.sv
// Sequence tracking and codepoint to code unit conversion for one byte.
`default_nettype none
module u8u16_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [7:0]      byte_q,
  input  wire logic            final_q,
  output u8u16_pkg::dec_out_t  dec
);
  import u8u16_pkg::*;

  logic [1:0]       pending;
  logic [1:0]       pending_next;
  logic [CodeW-1:0] partial;
  logic [CodeW-1:0] partial_next;
  logic             emit;
  logic [CodeW-1:0] cp;
  logic [CodeW-1:0] shifted;
  logic [CodeW-1:0] diff;
  logic [1:0]       left;

  assign shifted = {partial[CodeW-7:0], byte_q[5:0]};
  assign left    = pending - 2'd1;
  assign diff    = cp - SuppBase;

  always_comb begin
    pending_next = pending;
    partial_next = partial;
    emit         = 1'b0;
    cp           = '0;
    if (pending == 2'd0) begin
      unique case (byte_q[7:4]) inside
        NibLead2a, NibLead2b: begin
          pending_next = 2'd1;
          partial_next = {{(CodeW-5){1'b0}}, byte_q[4:0]};
        end
        NibLead3: begin
          pending_next = 2'd2;
          partial_next = {{(CodeW-4){1'b0}}, byte_q[3:0]};
        end
        NibLead4: begin
          pending_next = 2'd3;
          partial_next = {{(CodeW-3){1'b0}}, byte_q[2:0]};
        end
        default: begin
          // Plain ASCII and stray continuation bytes pass straight through.
          emit = 1'b1;
          cp   = {{(CodeW-8){1'b0}}, byte_q};
        end
      endcase
    end else begin
      pending_next = left;
      if (left == 2'd0) begin
        emit         = 1'b1;
        cp           = shifted;
        partial_next = '0;
      end else begin
        partial_next = shifted;
      end
    end
    // A sequence still open at the end of the string is thrown away.
    if (final_q && !emit) begin
      pending_next = 2'd0;
      partial_next = '0;
    end
  end

  always_comb begin
    dec = '0;
    if (emit) begin
      if (cp <= BmpMax) begin
        dec.count = 2'd1;
        dec.unit0 = cp[UnitW-1:0];
      end else begin
        dec.count = 2'd2;
        dec.unit0 = HighSurr + {5'd0, diff[CodeW-1:10]};
        dec.unit1 = {LowSurrHi, diff[9:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      partial <= '0;
    end else if (advance) begin
      pending <= pending_next;
      partial <= partial_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/u8u16_out_buf.sv
// Two-entry result buffer that hands code units out one word at a time.
`default_nettype none
module u8u16_out_buf (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  u8u16_pkg::dec_out_t             dec,
  output logic                            load_ok,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [u8u16_pkg::UnitW-1:0]     code_unit,
  output logic                            run_end
);
  import u8u16_pkg::*;

  logic [1:0]       count;
  logic [1:0]       count_next;
  logic [UnitW-1:0] unit0;
  logic [UnitW-1:0] unit1;
  logic             end0;
  logic             pop;
  logic             write;

  assign out_valid = (count != 2'd0);
  assign code_unit = unit0;
  assign run_end   = end0;
  assign pop       = out_valid && !out_stall;
  // A byte with no units never waits; otherwise room must be free this cycle.
  assign load_ok   = (dec.count == 2'd0) || (count == 2'd0) ||
                     ((count == 2'd1) && pop);
  assign write     = load && (dec.count != 2'd0);

  always_comb begin
    count_next = count;
    if (write) begin
      count_next = dec.count;
    end else if (pop) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      unit0 <= dec.unit0;
      unit1 <= dec.unit1;
      end0  <= (dec.count == 2'd1);
    end else if (pop) begin
      unit0 <= unit1;
      end0  <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/utf8_to_utf16_stream_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to UTF-16 stream transcoder.
module utf8_to_utf16_stream_top_test;
  import u8u16_pkg::*;

  typedef struct {
    logic [UnitW-1:0] unit;
    logic             last;
  } unit_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       byte_in = 8'h00;
  logic             final_byte = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [UnitW-1:0] code_unit;
  logic             run_end;

  // Predicted decoder state and the code units still owed by the block.
  unit_t            units_due[$];
  logic [1:0]       seq_left = '0;
  logic [CodeW-1:0] code_acc = '0;
  int               error_count = 0;
  bit               tx_gaps = 1'b1;
  bit               rx_gaps = 1'b1;
  bit               hold_off_req = 1'b0;

  utf8_to_utf16_stream_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_unit  (code_unit),
    .run_end    (run_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic add_due(input unit_t u);
    units_due = {units_due, u};
  endtask

  task automatic push_code(input logic [CodeW-1:0] cp);
    logic [CodeW-1:0] off;
    unit_t            u;
    if (cp <= BmpMax) begin
      u.unit = cp[UnitW-1:0];
      u.last = 1'b1;
      add_due(u);
    end else begin
      off = cp - SuppBase;
      u.unit = HighSurr + {5'd0, off[CodeW-1:10]};
      u.last = 1'b0;
      add_due(u);
      u.unit = {LowSurrHi, off[9:0]};
      u.last = 1'b1;
      add_due(u);
    end
  endtask

  task automatic predict_units(input logic [7:0] b, input logic fin);
    if (seq_left == 2'd0) begin
      case (b[7:4])
        NibLead2a, NibLead2b: begin
          code_acc = {{(CodeW-5){1'b0}}, b[4:0]};
          seq_left = 2'd1;
        end
        NibLead3: begin
          code_acc = {{(CodeW-4){1'b0}}, b[3:0]};
          seq_left = 2'd2;
        end
        NibLead4: begin
          code_acc = {{(CodeW-3){1'b0}}, b[2:0]};
          seq_left = 2'd3;
        end
        default: push_code({{(CodeW-8){1'b0}}, b});
      endcase
    end else begin
      // Whatever its top bits, a byte inside a sequence only adds six bits.
      code_acc = {code_acc[CodeW-7:0], b[5:0]};
      seq_left = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        push_code(code_acc);
        code_acc = '0;
      end
    end
    if (fin && seq_left != 2'd0) begin
      seq_left = '0;
      code_acc = '0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    byte_in    <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall);
    predict_units(b, fin);
  endtask

  // Sends the first keep bytes of a sequence of len bytes; fin marks the last one sent.
  task automatic send_char(input int len, input int keep, input bit fin, input bit noisy);
    logic [7:0] b;
    for (int i = 0; i < keep; i++) begin
      if (i == 0) begin
        case (len)
          1:       b = 8'($urandom_range(0, 8'hBF));
          2:       b = {3'b110, 5'($urandom)};
          3:       b = {4'b1110, 4'($urandom)};
          default: b = {4'b1111, 4'($urandom)};
        endcase
      end else begin
        b = noisy ? 8'($urandom) : {2'b10, 6'($urandom)};
      end
      send_byte(b, fin && i == keep - 1);
    end
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_sequences();
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // Largest value the payload bits allow, well beyond the Unicode range.
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // An ASCII byte and a lead byte standing in continuation positions.
    send_byte(8'hE1, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF5, 1'b1);
  endtask

  task automatic test_cut_short();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hF0, 1'b1);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_random_stream(input int n_items);
    int sent;
    int pick;
    int len;
    int keep;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      if (pick < 70) begin
        send_char(len, len, $urandom_range(0, 7) == 0, 1'b0);
        sent += len;
      end else if (pick < 80) begin
        send_char(len, len, $urandom_range(0, 5) == 0, 1'b1);
        sent += len;
      end else if (pick < 90) begin
        send_byte(8'($urandom), $urandom_range(0, 5) == 0);
        sent += 1;
      end else begin
        len  = $urandom_range(2, 4);
        keep = $urandom_range(1, len - 1);
        send_char(len, keep, 1'b1, 1'b0);
        sent += keep;
      end
    end
  endtask

  task automatic test_hold_off();
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_char(4, 4, 1'b0, 1'b0);
    end
  endtask

  initial begin : sink
    int    stall_left;
    unit_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          if (units_due.size() == 0) begin
            $error("unexpected code unit: code_unit expected none, actual %h", code_unit);
            error_count++;
          end else begin
            want = units_due.pop_front();
            if (code_unit !== want.unit) begin
              $error("code_unit: expected %h, actual %h", want.unit, code_unit);
              error_count++;
            end
            if (run_end !== want.last) begin
              $error("run_end: expected %b, actual %b", want.last, run_end);
              error_count++;
            end
          end
        end
        // A long hold-off lets the block fill up and stall its input.
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          stall_left = 300;
        end else if (stall_left == 0 && rx_gaps && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 6);
        end
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_bytes();
    test_sequences();
    test_cut_short();
    test_random_stream(900);
    test_hold_off();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random_stream(250);
    in_valid <= 1'b0;
    waited = 0;
    while (units_due.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (units_due.size() != 0) begin
      $error("%0d expected code units never arrived", units_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
